[hw/rtl/framebuffer_dirty_chunk_tracker_macros.svh]
// assertion helpers shared by the tracker modules
// every module that uses them has i_clk and an active-low i_rst_n
`ifndef FRAMEBUFFER_DIRTY_CHUNK_TRACKER_MACROS_SVH
`define FRAMEBUFFER_DIRTY_CHUNK_TRACKER_MACROS_SVH

// same-cycle implication
`define FDCT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fdct_pkg.sv]
`timescale 1ns / 1ps

package fdct_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    // item and result field widths
    localparam int OP_W      = 2;
    localparam int POS_W     = 8;
    localparam int BROW_W    = 4;
    localparam int BITS_W    = 16;
    localparam int PAGE_W    = 3;
    localparam int COL_OUT_W = 7;
    localparam int BYTE_W    = 8;

    // widest column index for any supported width
    localparam int COL_MAX_W = 8;

    localparam int PIX_MSB  = 15;
    localparam int BMP_W    = 16;
    localparam int DCOL_W   = $clog2(BMP_W) + 1;

    localparam int MAX_RUNS = 64;
    localparam int NRUN_W   = $clog2(MAX_RUNS);

    localparam logic [BYTE_W-1:0] FILL_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_CLEAR = 8'hFF;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        RUN_IDLE,
        RUN_BEGIN,
        RUN_COL,
        RUN_CLOSE,
        RUN_FLUSH
    } t_run_op;

    typedef struct packed {
        t_run_op                op;
        logic                   diff;
        logic [COL_MAX_W-1:0]   col;
        logic [PAGE_W-1:0]      page;
    } t_run_cmd;

endpackage

[hw/rtl/fdct_if.sv]
`timescale 1ns / 1ps

interface fdct_in_if;
    logic                               valid;
    logic                               ready;
    logic [fdct_pkg::OP_W-1:0]          operation;
    logic [fdct_pkg::POS_W-1:0]         pos_x;
    logic [fdct_pkg::POS_W-1:0]         pos_y;
    logic [fdct_pkg::BROW_W-1:0]        bitmap_row;
    logic [fdct_pkg::BITS_W-1:0]        row_bits;
    logic [fdct_pkg::PAGE_W-1:0]        page_select;

    modport source (
        output valid, operation, pos_x, pos_y, bitmap_row, row_bits, page_select,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, bitmap_row, row_bits, page_select,
        output ready
    );
endinterface

interface fdct_out_if;
    logic                               valid;
    logic                               ready;
    logic [fdct_pkg::PAGE_W-1:0]        chunk_page;
    logic [fdct_pkg::COL_OUT_W-1:0]     chunk_start;
    logic [fdct_pkg::COL_OUT_W-1:0]     chunk_end;
    logic                               has_chunk;
    logic                               last;

    modport source (
        output valid, chunk_page, chunk_start, chunk_end, has_chunk, last,
        input  ready
    );
    modport sink (
        input  valid, chunk_page, chunk_start, chunk_end, has_chunk, last,
        output ready
    );
endinterface

[hw/rtl/fdct_ram.sv]
`timescale 1ns / 1ps

module fdct_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fdct_runs.sv]
`timescale 1ns / 1ps
`include "framebuffer_dirty_chunk_tracker_macros.svh"

module fdct_runs #(
    parameter int WIDTH = fdct_pkg::DEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdct_pkg::t_run_cmd  i_cmd,
    output logic                o_taken,
    fdct_out_if.source          o_out
);

    localparam int CW = $clog2(WIDTH);

    logic                           r_open, n_open;
    logic [CW-1:0]                  r_start, n_start;
    logic [CW-1:0]                  r_lastdiff, n_lastdiff;
    logic [fdct_pkg::NRUN_W-1:0]    r_nrun, n_nrun;
    logic                           r_pend_v, n_pend_v;
    logic [CW-1:0]                  r_pend_start, n_pend_start;
    logic [CW-1:0]                  r_pend_end, n_pend_end;
    logic [fdct_pkg::PAGE_W-1:0]    r_page, n_page;

    logic                           r_ov;
    logic [fdct_pkg::PAGE_W-1:0]    r_o_page;
    logic [fdct_pkg::COL_OUT_W-1:0] r_o_start;
    logic [fdct_pkg::COL_OUT_W-1:0] r_o_end;
    logic                           r_o_has;
    logic                           r_o_last;

    logic           can_push;
    logic           closing;
    logic [CW-1:0]  col;
    logic           push;
    logic           push_has;
    logic           push_last;
    logic [CW-1:0]  push_start;
    logic [CW-1:0]  push_end;

    assign col      = i_cmd.col[CW-1:0];
    assign can_push = !r_ov || o_out.ready;
    // a run only closes on a clean column while the run budget lasts
    assign closing  = !i_cmd.diff && r_open &&
                      (r_nrun < fdct_pkg::NRUN_W'(fdct_pkg::MAX_RUNS - 1));

    always_comb begin
        n_open       = r_open;
        n_start      = r_start;
        n_lastdiff   = r_lastdiff;
        n_nrun       = r_nrun;
        n_pend_v     = r_pend_v;
        n_pend_start = r_pend_start;
        n_pend_end   = r_pend_end;
        n_page       = r_page;
        o_taken      = 1'b0;
        push         = 1'b0;
        push_has     = 1'b1;
        push_last    = 1'b0;
        push_start   = r_pend_start;
        push_end     = r_pend_end;

        unique case (i_cmd.op)
            fdct_pkg::RUN_BEGIN: begin
                o_taken  = 1'b1;
                n_open   = 1'b0;
                n_nrun   = '0;
                n_pend_v = 1'b0;
                n_page   = i_cmd.page;
            end
            fdct_pkg::RUN_COL: begin
                o_taken = !(closing && r_pend_v) || can_push;
                if (o_taken) begin
                    if (closing) begin
                        // the held run is not the last one, so it goes out now
                        push         = r_pend_v;
                        n_pend_v     = 1'b1;
                        n_pend_start = r_start;
                        n_pend_end   = col - CW'(1);
                        n_nrun       = r_nrun + fdct_pkg::NRUN_W'(1);
                        n_open       = 1'b0;
                    end
                    if (i_cmd.diff) begin
                        n_lastdiff = col;
                        if (!r_open) begin
                            n_open  = 1'b1;
                            n_start = col;
                        end
                    end
                end
            end
            fdct_pkg::RUN_CLOSE: begin
                o_taken = !(r_open && r_pend_v) || can_push;
                if (o_taken && r_open) begin
                    push         = r_pend_v;
                    n_pend_v     = 1'b1;
                    n_pend_start = r_start;
                    n_pend_end   = r_lastdiff;
                    n_open       = 1'b0;
                end
            end
            fdct_pkg::RUN_FLUSH: begin
                o_taken = can_push;
                if (o_taken) begin
                    // no run held means an unchanged page
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_has   = r_pend_v;
                    push_start = r_pend_v ? r_pend_start : '0;
                    push_end   = r_pend_v ? r_pend_end : '0;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
                o_taken = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_lastdiff   <= n_lastdiff;
        r_pend_start <= n_pend_start;
        r_pend_end   <= n_pend_end;
        r_page       <= n_page;
        if (push) begin
            r_o_page  <= r_page;
            r_o_start <= fdct_pkg::COL_OUT_W'(push_start);
            r_o_end   <= fdct_pkg::COL_OUT_W'(push_end);
            r_o_has   <= push_has;
            r_o_last  <= push_last;
        end
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_nrun   <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_open   <= n_open;
            r_nrun   <= n_nrun;
            r_pend_v <= n_pend_v;
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.chunk_page  = r_o_page;
    assign o_out.chunk_start = r_o_start;
    assign o_out.chunk_end   = r_o_end;
    assign o_out.has_chunk   = r_o_has;
    assign o_out.last        = r_o_last;

    `FDCT_ASSERT_IMPL(a_push_into_free, push, !r_ov || o_out.ready, "result register overrun")
    `FDCT_ASSERT_IMPL(a_empty_is_last, push && !push_has, push_last, "empty result not last")
    `FDCT_ASSERT_NEXT(a_stall_holds, (i_cmd.op == fdct_pkg::RUN_COL) && !o_taken, $stable(r_nrun) && $stable(r_pend_v), "run state moved during stall")
    `FDCT_ASSERT_NEXT(a_flush_empties, (i_cmd.op == fdct_pkg::RUN_FLUSH) && o_taken, !r_pend_v && !r_open, "run left after flush")

endmodule

[hw/rtl/framebuffer_dirty_chunk_tracker.sv]
`timescale 1ns / 1ps
`include "framebuffer_dirty_chunk_tracker_macros.svh"
// Dirty-region tracker for a page-organised monochrome frame.
// i_in takes one transaction per item: clear, draw one bitmap row, or update
// one page. o_out gives one transaction per changed run of columns of an
// updated page; an unchanged or out-of-range page gives a single empty result.
// The frame and the shadow of what was last sent sit in two 8-bit RAMs of
// WIDTH * pages bytes, with registered read data.
// Clear: one write per byte, WIDTH * pages writes (1024 by default).
// Draw row: one read-modify-write per set, on-screen bitmap pixel, pipelined.
// Update page: one column per cycle when o_out keeps up; each run is held
// until the next one closes and leaves in the cycle after that, and the
// final result, marked last, leaves from the flush step after the close step.
// i_in.ready is high only while no item is in progress.
// Results wait in a one-deep output register; when the receiver stalls and a
// second run has to leave, the column scan pauses until the register frees.
// After reset both RAMs are zeroed by a sweep over all WIDTH * pages bytes,
// during which no item is taken.

module framebuffer_dirty_chunk_tracker #(
    parameter int WIDTH  = fdct_pkg::DEF_WIDTH,
    parameter int HEIGHT = fdct_pkg::DEF_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdct_in_if.sink     i_in,
    fdct_out_if.source  o_out
);

    localparam int PAGES      = (HEIGHT + 7) / 8;
    localparam int STORE_SIZE = WIDTH * PAGES;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int CW         = $clog2(WIDTH);
    localparam int PX_W       = fdct_pkg::POS_W + 1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DRAW,
        S_SCAN,
        S_CLOSE,
        S_FLUSH
    } t_state;

    t_state                         r_state, n_state;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [fdct_pkg::BYTE_W-1:0]    r_fill, n_fill;
    logic                           r_wr_valid, n_wr_valid;
    logic [AW-1:0]                  r_wr_addr, n_wr_addr;
    logic [AW-1:0]                  r_base, n_base;
    logic [PX_W-1:0]                r_px, n_px;
    logic [fdct_pkg::BITS_W-1:0]    r_bits, n_bits;
    logic [fdct_pkg::BYTE_W-1:0]    r_mask, n_mask;
    logic [fdct_pkg::DCOL_W-1:0]    r_dcol, n_dcol;
    logic [CW-1:0]                  r_col, n_col;

    logic                           fr_we, sh_we, fr_re, sh_re;
    logic [AW-1:0]                  fr_waddr, sh_waddr, rd_addr;
    logic [fdct_pkg::BYTE_W-1:0]    fr_wdata, sh_wdata, fr_rdata, sh_rdata;
    logic [PX_W-1:0]                py;
    logic                           pixel_ok;
    logic [AW-1:0]                  draw_addr;
    logic [AW-1:0]                  scan_base;
    fdct_pkg::t_run_cmd             run_cmd;
    logic                           run_taken;

    assign py        = PX_W'(i_in.pos_y) + PX_W'(i_in.bitmap_row);
    assign pixel_ok  = r_bits[fdct_pkg::PIX_MSB] && (r_px < WIDTH);
    assign draw_addr = r_base + AW'(r_px);
    assign scan_base = AW'(int'(i_in.page_select) * WIDTH);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_fill     = r_fill;
        n_wr_valid = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_base     = r_base;
        n_px       = r_px;
        n_bits     = r_bits;
        n_mask     = r_mask;
        n_dcol     = r_dcol;
        n_col      = r_col;

        i_in.ready   = (r_state == S_IDLE);
        run_cmd.op   = fdct_pkg::RUN_IDLE;
        run_cmd.diff = (fr_rdata != sh_rdata);
        run_cmd.col  = fdct_pkg::COL_MAX_W'(r_col);
        run_cmd.page = i_in.page_select;

        fr_we    = r_wr_valid;
        fr_waddr = r_wr_addr;
        fr_wdata = fr_rdata | r_mask;
        sh_we    = 1'b0;
        sh_waddr = r_base + AW'(r_col);
        sh_wdata = fr_rdata;
        fr_re    = 1'b0;
        sh_re    = 1'b0;
        rd_addr  = draw_addr;

        unique case (r_state)
            S_CLR: begin
                fr_we    = 1'b1;
                fr_waddr = r_addr;
                fr_wdata = '0;
                sh_we    = 1'b1;
                sh_waddr = r_addr;
                sh_wdata = r_fill;
                n_addr   = r_addr + AW'(1);
                if (r_addr == AW'(STORE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.operation)
                        fdct_pkg::OP_CLEAR: begin
                            n_fill  = fdct_pkg::FILL_CLEAR;
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        fdct_pkg::OP_DRAW: begin
                            // whole row dropped if it starts off screen
                            if ((i_in.pos_x < WIDTH) && (py < HEIGHT)) begin
                                n_base  = AW'(int'(py[PX_W-1:3]) * WIDTH);
                                n_px    = PX_W'(i_in.pos_x);
                                n_bits  = i_in.row_bits;
                                n_mask  = fdct_pkg::BYTE_W'(1) << py[2:0];
                                n_dcol  = '0;
                                n_state = S_DRAW;
                            end
                        end
                        fdct_pkg::OP_UPDATE: begin
                            run_cmd.op = fdct_pkg::RUN_BEGIN;
                            if (i_in.page_select < PAGES) begin
                                n_base  = scan_base;
                                rd_addr = scan_base;
                                fr_re   = 1'b1;
                                sh_re   = 1'b1;
                                n_col   = '0;
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAW: begin
                // read pixel k while pixel k-1 is written back
                if (!r_dcol[fdct_pkg::DCOL_W-1]) begin
                    fr_re      = pixel_ok;
                    n_wr_valid = pixel_ok;
                    n_wr_addr  = draw_addr;
                    n_bits     = r_bits << 1;
                    n_px       = r_px + PX_W'(1);
                    n_dcol     = r_dcol + fdct_pkg::DCOL_W'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                run_cmd.op = fdct_pkg::RUN_COL;
                if (run_taken) begin
                    sh_we = 1'b1;
                    if (r_col == CW'(WIDTH - 1)) begin
                        n_state = S_CLOSE;
                    end else begin
                        fr_re   = 1'b1;
                        sh_re   = 1'b1;
                        rd_addr = r_base + AW'(r_col) + AW'(1);
                        n_col   = r_col + CW'(1);
                    end
                end
            end
            S_CLOSE: begin
                run_cmd.op = fdct_pkg::RUN_CLOSE;
                if (run_taken) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                run_cmd.op = fdct_pkg::RUN_FLUSH;
                if (run_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_base    <= n_base;
        r_px      <= n_px;
        r_bits    <= n_bits;
        r_mask    <= n_mask;
        r_dcol    <= n_dcol;
        r_col     <= n_col;
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_fill     <= fdct_pkg::FILL_RESET;
            r_wr_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_fill     <= n_fill;
            r_wr_valid <= n_wr_valid;
        end
    end

    fdct_ram #(
        .DATA_W (fdct_pkg::BYTE_W),
        .DEPTH  (STORE_SIZE)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (rd_addr),
        .o_rdata (fr_rdata)
    );

    fdct_ram #(
        .DATA_W (fdct_pkg::BYTE_W),
        .DEPTH  (STORE_SIZE)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (sh_waddr),
        .i_wdata (sh_wdata),
        .i_re    (sh_re),
        .i_raddr (rd_addr),
        .o_rdata (sh_rdata)
    );

    fdct_runs #(
        .WIDTH (WIDTH)
    ) u_runs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (run_cmd),
        .o_taken (run_taken),
        .o_out   (o_out)
    );

    `FDCT_ASSERT_IMPL(a_draw_write_only, r_wr_valid, r_state == S_DRAW, "frame write outside draw")
    `FDCT_ASSERT_NEXT(a_scan_stall_hold, (r_state == S_SCAN) && !run_taken, $stable(r_col) && (r_state == S_SCAN), "scan moved during stall")
    `FDCT_ASSERT_IMPL(a_scan_in_page, r_state == S_SCAN, r_col <= CW'(WIDTH - 1), "scan column past page end")

endmodule
